>>> rtl/bmhpq_pkg.sv
// Shared types for the binary min-heap priority queue: heap entry, error
// codes, controller states and the controller/datapath command and status.
// No dependencies.
`default_nettype none

package bmhpq_pkg;

  typedef struct packed {
    logic signed [31:0] prio;
    logic        [31:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHECK,
    ST_UP_CMP,
    ST_DN_LOAD,
    ST_DN_CHECK,
    ST_DN_CMP,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_UP_CHECK,
    OP_UP_CMP,
    OP_DN_LOAD,
    OP_DN_CHECK,
    OP_DN_CMP,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic cnt_one;
    logic up_root;
    logic up_less;
    logic dn_leaf;
    logic dn_swap;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/bmhpq_ctrl.sv
// Controller for the heap queue: sequences accept, sift-up, sift-down and
// result load. Depends on bmhpq_pkg.
`default_nettype none

module bmhpq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_mode,
  output logic                in_ready,
  input  bmhpq_pkg::dp_stat_t stat,
  output bmhpq_pkg::dp_cmd_t  cmd
);
  import bmhpq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (!in_mode) begin
            state_nxt = stat.full ? ST_FINISH : ST_UP_CHECK;
          end else if (stat.empty || stat.cnt_one) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_DN_LOAD;
          end
        end
      end
      ST_UP_CHECK: state_nxt = stat.up_root ? ST_FINISH : ST_UP_CMP;
      ST_UP_CMP:   state_nxt = stat.up_less ? ST_UP_CHECK : ST_FINISH;
      ST_DN_LOAD:  state_nxt = ST_DN_CHECK;
      ST_DN_CHECK: state_nxt = stat.dn_leaf ? ST_FINISH : ST_DN_CMP;
      ST_DN_CMP:   state_nxt = stat.dn_swap ? ST_DN_CHECK : ST_FINISH;
      ST_FINISH: begin
        if (!stat.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
        end
      end
      ST_UP_CHECK: cmd.op = OP_UP_CHECK;
      ST_UP_CMP:   cmd.op = OP_UP_CMP;
      ST_DN_LOAD:  cmd.op = OP_DN_LOAD;
      ST_DN_CHECK: cmd.op = OP_DN_CHECK;
      ST_DN_CMP:   cmd.op = OP_DN_CMP;
      ST_FINISH: begin
        if (!stat.out_busy) begin
          cmd.op = OP_FINISH;
        end
      end
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/bmhpq_dp.sv
// Datapath for the heap queue: entry memory, count, moving entry and hole
// index, head copy and output register. Depends on bmhpq_pkg.
`default_nettype none

module bmhpq_dp #(
  parameter int CAPACITY = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bmhpq_pkg::dp_cmd_t  cmd,
  output bmhpq_pkg::dp_stat_t stat,
  input  logic                in_mode,
  input  logic [31:0]         in_value,
  input  logic signed [31:0]  in_priority_req,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_removed_value,
  output logic signed [31:0]  out_removed_priority,
  output logic                out_removed_valid,
  output logic [31:0]         out_head_value,
  output logic signed [31:0]  out_head_priority,
  output logic                out_is_empty,
  output logic [1:0]          out_error_code
);
  import bmhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  entry_t mem [CAPACITY];
  entry_t rd_a_r, rd_b_r;
  logic [AW-1:0] rd_a_addr, rd_b_addr, waddr;
  logic   we;
  entry_t wdata;

  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  entry_t mov_r, mov_nxt;
  entry_t head_r, head_nxt;
  entry_t rem_r, rem_nxt;
  logic   rem_ok_r, rem_ok_nxt;
  err_t   err_r, err_nxt;

  logic   out_valid_r, out_valid_nxt;
  entry_t o_rem_r, o_rem_nxt;
  logic   o_rem_ok_r, o_rem_ok_nxt;
  entry_t o_head_r, o_head_nxt;
  logic   o_empty_r, o_empty_nxt;
  err_t   o_err_r, o_err_nxt;

  logic [XW-1:0] cnt_x, left_x, right_x;
  logic [CW-1:0] cnt_dec;
  logic [AW-1:0] parent, pick_idx;
  logic   full, empty, right_ok, pick_right, up_less, dn_swap, dn_leaf;
  entry_t pick;

  assign cnt_x   = XW'(count_r);
  assign left_x  = XW'({idx_r, 1'b1});
  assign right_x = left_x + XW'(1);
  assign cnt_dec = count_r - CW'(1);
  assign parent  = (idx_r - AW'(1)) >> 1;

  assign full       = (count_r == CW'(CAPACITY));
  assign empty      = (count_r == '0);
  assign up_less    = (mov_r.prio < rd_a_r.prio);
  assign dn_leaf    = (left_x >= cnt_x);
  assign right_ok   = (right_x < cnt_x);
  // prefer the left child unless the right one is strictly smaller
  assign pick_right = right_ok && (rd_b_r.prio < rd_a_r.prio);
  assign pick       = pick_right ? rd_b_r : rd_a_r;
  assign pick_idx   = pick_right ? right_x[AW-1:0] : left_x[AW-1:0];
  assign dn_swap    = (pick.prio < mov_r.prio);

  assign stat.full     = full;
  assign stat.empty    = empty;
  assign stat.cnt_one  = (count_r == CW'(1));
  assign stat.up_root  = (idx_r == '0);
  assign stat.up_less  = up_less;
  assign stat.dn_leaf  = dn_leaf;
  assign stat.dn_swap  = dn_swap;
  assign stat.out_busy = out_valid_r && !out_ready;

  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    mov_nxt       = mov_r;
    rem_nxt       = rem_r;
    rem_ok_nxt    = rem_ok_r;
    err_nxt       = err_r;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = mov_r;
    rd_a_addr     = parent;
    rd_b_addr     = parent;
    out_valid_nxt = out_valid_r && !out_ready;
    o_rem_nxt     = o_rem_r;
    o_rem_ok_nxt  = o_rem_ok_r;
    o_head_nxt    = o_head_r;
    o_empty_nxt   = o_empty_r;
    o_err_nxt     = o_err_r;
    unique case (cmd.op)
      OP_NONE: begin
      end
      OP_ACCEPT: begin
        rem_nxt    = '0;
        rem_ok_nxt = 1'b0;
        err_nxt    = ERR_NONE;
        if (!in_mode) begin
          if (full) begin
            err_nxt = ERR_FULL;
          end else begin
            mov_nxt.prio  = in_priority_req;
            mov_nxt.value = in_value;
            idx_nxt       = count_r[AW-1:0];
            count_nxt     = count_r + CW'(1);
          end
        end else if (empty) begin
          err_nxt = ERR_EMPTY;
        end else begin
          rem_nxt    = head_r;
          rem_ok_nxt = 1'b1;
          count_nxt  = cnt_dec;
          // fetch the last word; it becomes the new root
          rd_a_addr  = cnt_dec[AW-1:0];
        end
      end
      OP_UP_CHECK: begin
        if (idx_r == '0) begin
          we = 1'b1;
        end
      end
      OP_UP_CMP: begin
        we = 1'b1;
        if (up_less) begin
          wdata   = rd_a_r;
          idx_nxt = parent;
        end
      end
      OP_DN_LOAD: begin
        mov_nxt = rd_a_r;
        idx_nxt = '0;
      end
      OP_DN_CHECK: begin
        if (dn_leaf) begin
          we = 1'b1;
        end else begin
          rd_a_addr = left_x[AW-1:0];
          rd_b_addr = right_ok ? right_x[AW-1:0] : left_x[AW-1:0];
        end
      end
      OP_DN_CMP: begin
        we = 1'b1;
        if (dn_swap) begin
          wdata   = pick;
          idx_nxt = pick_idx;
        end
      end
      OP_FINISH: begin
        out_valid_nxt = 1'b1;
        o_rem_nxt     = rem_r;
        o_rem_ok_nxt  = rem_ok_r;
        o_head_nxt    = empty ? '0 : head_r;
        o_empty_nxt   = empty;
        o_err_nxt     = err_r;
      end
      default: begin
      end
    endcase
  end

  // keep a copy of the root so the head is always at hand
  assign head_nxt = (we && (waddr == '0)) ? wdata : head_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_r <= mem[rd_a_addr];
    rd_b_r <= mem[rd_b_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    mov_r      <= mov_nxt;
    head_r     <= head_nxt;
    rem_r      <= rem_nxt;
    rem_ok_r   <= rem_ok_nxt;
    err_r      <= err_nxt;
    o_rem_r    <= o_rem_nxt;
    o_rem_ok_r <= o_rem_ok_nxt;
    o_head_r   <= o_head_nxt;
    o_empty_r  <= o_empty_nxt;
    o_err_r    <= o_err_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_removed_value    = o_rem_r.value;
  assign out_removed_priority = o_rem_r.prio;
  assign out_removed_valid    = o_rem_ok_r;
  assign out_head_value       = o_head_r.value;
  assign out_head_priority    = o_head_r.prio;
  assign out_is_empty         = o_empty_r;
  assign out_error_code       = o_err_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_hole_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_UP_CMP || cmd.op == OP_DN_CMP) |-> (XW'(idx_r) < cnt_x))
    else $error("hole index outside the heap");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_ACCEPT && in_mode && !empty) |=>
      (count_r == $past(count_r) - CW'(1)))
    else $error("remove did not drop the count");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_empty_r) |-> (o_head_r == '0))
    else $error("empty queue reports a head");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_FINISH) |-> !(out_valid_r && !out_ready))
    else $error("result loaded over a pending word");
`endif

endmodule

`default_nettype wire

>>> rtl/binary_min_heap_priority_queue_core.sv
// Binary min-heap priority queue, top level. Instantiates bmhpq_ctrl and
// bmhpq_dp; depends on bmhpq_pkg.
//
// Input channel (in_valid/in_ready): in_mode 0 inserts {in_value,
// in_priority_req}, in_mode 1 removes the entry with the lowest priority.
// Output channel (out_valid/out_ready): one result word per input word with
// the removed entry, the head after the operation, an empty flag and an
// error code (remove on empty, insert on full; such words change nothing).
// One word is worked on at a time; in_ready is high only while idle.
// Insert sifts the entry up from the new last slot; each level is a
// registered memory read of the parent and a compare and write. Remove
// loads the last entry as the new root and sifts it down; each level is a
// registered read of both children and a compare and write. At most
// log2(CAPACITY) levels are moved. Errors and a remove that empties the
// queue go straight from the accept to the result load.
// A finished result sits in an output register; a new word is accepted
// while it waits, and the next result waits for out_ready before loading.
// Reset empties the queue and drops any pending result; the entry memory
// is not cleared, as only slots below the count are read.
`default_nettype none

module binary_min_heap_priority_queue_core #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_mode,
  input  logic [31:0]        in_value,
  input  logic signed [31:0] in_priority_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_removed_value,
  output logic signed [31:0] out_removed_priority,
  output logic               out_removed_valid,
  output logic [31:0]        out_head_value,
  output logic signed [31:0] out_head_priority,
  output logic               out_is_empty,
  output logic [1:0]         out_error_code
);
  import bmhpq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bmhpq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bmhpq_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .in_mode              (in_mode),
    .in_value             (in_value),
    .in_priority_req      (in_priority_req),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_removed_value    (out_removed_value),
    .out_removed_priority (out_removed_priority),
    .out_removed_valid    (out_removed_valid),
    .out_head_value       (out_head_value),
    .out_head_priority    (out_head_priority),
    .out_is_empty         (out_is_empty),
    .out_error_code       (out_error_code)
  );

endmodule

`default_nettype wire
